// ===== design/upd_pkg.sv =====
// Shared constants, register indexes and hex helpers for the URL percent decoder.
package upd_pkg;

   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   // Results that one input item can cause, and the depth of the result buffer.
   localparam int MAX_RESULTS = 3;
   localparam int BUF_DEPTH   = 4;

   typedef enum logic {
      REG_COPY_QUERY = 1'b0,
      REG_SLASH_MAP  = 1'b1
   } reg_index_type;

   // True for the ASCII hex digits 0-9, A-F and a-f.
   function automatic logic is_hex_byte(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   // Value of a hex digit; only meaningful when is_hex_byte holds.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61) begin
         v = c - 8'h61 + 8'd10;
      end else begin
         v = c - 8'h41 + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

// ===== design/upd_channels.sv =====
// Valid/ready channel interfaces for the decoder's request and response streams.
interface upd_req_if #(parameter int UNIT_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [UNIT_BITS-1:0] code_unit;
   logic                 last_unit;

   modport source (output valid, code_unit, last_unit, input ready);
   modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface upd_rsp_if #(parameter int UNIT_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [UNIT_BITS-1:0] out_unit;
   logic                 has_unit;
   logic                 end_of_string;

   modport source (output valid, out_unit, has_unit, end_of_string, input ready);
   modport sink   (input valid, out_unit, has_unit, end_of_string, output ready);
endinterface

// ===== design/url_percent_decoder_top.sv =====
// Top level of the streaming URL percent decoder with its register port.
//
// The decoder takes one code unit per request transfer and turns "%hh" escapes into the
// decoded byte value; a percent sign not followed by two hex digits passes through as is.
// Each accepted unit is decoded in the cycle it is accepted and its zero to three results
// are written into a four-entry result buffer whose head drives the response channel, so
// results are registered before they are offered. Requests are taken every cycle as long as
// the buffer, after this cycle's response transfer, holds at most one entry; an item that
// yields two or three results, which can happen when a held escape is released, therefore
// holds off further requests, paid back by the items that were held, and a stream in which
// each unit yields at most one result runs at one unit per clock while the response channel
// is ready. Every string ends in exactly one result with end_of_string set; a final unit that
// yields no character produces a bare end marker with has_unit low. The two control registers
// sit at byte addresses 0 and 4 and should only be written while the decoder is idle.
module url_percent_decoder_top
   import upd_pkg::*;
#(
   parameter int UNIT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   upd_req_if.sink     req_chan,
   upd_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef struct packed {
      logic [UNIT_BITS-1:0] unit;
      logic                 has;
      logic                 eos;
   } result_type;

   localparam int CNT_BITS = $clog2(BUF_DEPTH + 1);
   localparam int IDX_BITS = $clog2(BUF_DEPTH);

   // Control registers.
   logic copy_query_ff, slash_map_ff;

   // Decoder state.
   logic [1:0]           held_count_ff, held_count_in;
   logic [UNIT_BITS-1:0] held_digit_ff, held_digit_in;
   logic                 in_query_ff, in_query_in;
   logic                 stopped_ff, stopped_in;

   // Result buffer; entry 0 is the head.
   result_type          slot_ff [BUF_DEPTH];
   result_type          slot_in [BUF_DEPTH];
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic                accept, pop;
   logic [CNT_BITS-1:0] base;

   // ------------------------------------------------------------------
   // Register port. The word index is paddr[2]; writes land in the access phase.
   // ------------------------------------------------------------------
   assign pready = 1'b1;

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_COPY_QUERY: prdata = {31'd0, copy_query_ff};
         REG_SLASH_MAP:  prdata = {31'd0, slash_map_ff};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_query_ff <= 1'b1;
         slash_map_ff  <= 1'b1;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[2]))
            REG_COPY_QUERY: copy_query_ff <= pwdata[0];
            REG_SLASH_MAP:  slash_map_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Decode of the incoming unit.
   // ------------------------------------------------------------------
   logic [UNIT_BITS-1:0] c;
   logic                 last;
   logic                 c_is_hex, c_upper_zero, digit_upper_zero;
   logic [7:0]           decoded;

   assign c                = req_chan.code_unit;
   assign last             = req_chan.last_unit;
   assign c_upper_zero     = (c >> 8) == '0;
   assign digit_upper_zero = (held_digit_ff >> 8) == '0;
   assign c_is_hex         = c_upper_zero && is_hex_byte(c[7:0]);
   assign decoded          = {hex_nibble(held_digit_ff[7:0]), hex_nibble(c[7:0])};

   // Handling of a unit with nothing held.
   logic                 pl_emit, pl_stop, pl_hold;
   logic [UNIT_BITS-1:0] pl_unit;

   always_comb begin
      pl_emit = 1'b0;
      pl_stop = stopped_ff;
      pl_hold = 1'b0;
      pl_unit = c;
      if (!stopped_ff) begin
         if (c == UNIT_BITS'(CH_QMARK) && !copy_query_ff) begin
            pl_stop = 1'b1;
         end else if (c == UNIT_BITS'(CH_PCT)) begin
            pl_emit = last;
            pl_hold = !last;
         end else if (c == UNIT_BITS'(CH_SLASH) && in_query_ff && slash_map_ff) begin
            pl_emit = 1'b1;
            pl_unit = UNIT_BITS'(CH_BSLASH);
         end else begin
            pl_emit = 1'b1;
         end
      end
   end

   // Results of this unit: up to two flushed units or one decoded byte, then the plain result.
   result_type      res [MAX_RESULTS];
   logic [1:0]      n_res;
   logic [1:0]      n_pre;
   logic            use_plain;
   result_type      pre0, pre1, tail;

   always_comb begin
      n_pre         = 2'd0;
      use_plain     = 1'b0;
      pre0          = '{unit: UNIT_BITS'(CH_PCT), has: 1'b1, eos: 1'b0};
      pre1          = '{unit: held_digit_ff, has: 1'b1, eos: 1'b0};
      held_count_in = held_count_ff;
      held_digit_in = held_digit_ff;
      in_query_in   = in_query_ff;
      stopped_in    = stopped_ff;

      case (held_count_ff)
         2'd1: begin
            if (c_is_hex) begin
               if (last) begin
                  n_pre         = 2'd2;
                  pre1.unit     = c;
                  held_count_in = 2'd0;
               end else begin
                  held_digit_in = c;
                  held_count_in = 2'd2;
               end
            end else begin
               n_pre     = 2'd1;
               use_plain = 1'b1;
            end
         end
         2'd2: begin
            held_digit_in = '0;
            held_count_in = 2'd0;
            if (c_is_hex && digit_upper_zero) begin
               n_pre     = 2'd1;
               pre0.unit = UNIT_BITS'(decoded);
               if (decoded == CH_QMARK) begin
                  in_query_in = 1'b1;
               end
            end else begin
               n_pre     = 2'd2;
               use_plain = 1'b1;
            end
         end
         default: begin
            use_plain = 1'b1;
         end
      endcase

      if (use_plain) begin
         held_count_in = {1'b0, pl_hold};
         stopped_in    = pl_stop;
      end

      tail   = '{unit: pl_unit, has: 1'b1, eos: 1'b0};
      res[0] = (n_pre != 2'd0) ? pre0 : tail;
      res[1] = (n_pre == 2'd2) ? pre1 : tail;
      res[2] = tail;
      n_res  = n_pre + 2'(use_plain && pl_emit);

      if (last) begin
         if (n_res == 2'd0) begin
            res[0] = '{unit: '0, has: 1'b0, eos: 1'b0};
            n_res  = 2'd1;
         end
         case (n_res)
            2'd1:    res[0].eos = 1'b1;
            2'd2:    res[1].eos = 1'b1;
            default: res[2].eos = 1'b1;
         endcase
         held_count_in = 2'd0;
         held_digit_in = '0;
         in_query_in   = 1'b0;
         stopped_in    = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Result buffer and handshakes.
   // ------------------------------------------------------------------
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign base           = cnt_ff - CNT_BITS'(pop);
   assign req_chan.ready = base <= CNT_BITS'(1);
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid         = cnt_ff != '0;
   assign rsp_chan.out_unit      = slot_ff[0].unit;
   assign rsp_chan.has_unit      = slot_ff[0].has;
   assign rsp_chan.end_of_string = slot_ff[0].eos;

   // The head moves up on a response transfer; new results land just above what stays.
   always_comb begin
      for (int j = 0; j < BUF_DEPTH; j++) begin
         slot_in[j] = slot_ff[j];
      end
      if (pop) begin
         for (int j = 0; j < BUF_DEPTH - 1; j++) begin
            slot_in[j] = slot_ff[j+1];
         end
      end
      if (accept) begin
         for (int j = 0; j < MAX_RESULTS; j++) begin
            if (base == '0) begin
               slot_in[j] = res[j];
            end else if (base == CNT_BITS'(1)) begin
               slot_in[j+1] = res[j];
            end
         end
      end
      cnt_in = base + (accept ? CNT_BITS'(n_res) : '0);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         cnt_ff        <= '0;
         held_count_ff <= 2'd0;
         held_digit_ff <= '0;
         in_query_ff   <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            held_count_ff <= held_count_in;
            held_digit_ff <= held_digit_in;
            in_query_ff   <= in_query_in;
            stopped_ff    <= stopped_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(BUF_DEPTH))
      else $error("result buffer overfilled");

   a_held_code: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("held count out of range");

   a_stop_no_hold: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> held_count_ff == 2'd0)
      else $error("units held while output is stopped");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> held_count_ff == 2'd0 && !in_query_ff && !stopped_ff)
      else $error("state not cleared at end of string");

   a_last_gives_eos: assert property (@(posedge clock) disable iff (reset)
      accept && last && base == '0 |=> slot_ff[IDX_BITS'(cnt_ff - CNT_BITS'(1))].eos)
      else $error("end of string not marked on final result");

endmodule
